[rtl/mps_pkg.sv]
// ----------------------------------------------------------------------------
// mps_pkg: shared constants and types for the max pooling stream
// Register indexes, configuration port widths and the fixed counter widths
// used by the pooling block, its channel interfaces and its testbench.
// ----------------------------------------------------------------------------
package mps_pkg;

  // Configuration write channel.
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 16;

  // Height and depth registers, and the row and channel counters.
  localparam int unsigned DIM_BITS   = 11;
  localparam int unsigned COUNT_BITS = 10;
  localparam int unsigned DIM_LIMIT  = 1024;

  // Register reset values that do not depend on a parameter.
  localparam int unsigned HEIGHT_RESET = 1024;
  localparam int unsigned DEPTH_RESET  = 1;
  localparam int unsigned WINDOW_RESET = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAP_WIDTH   = 2'd0,
    REG_MAP_HEIGHT  = 2'd1,
    REG_MAP_DEPTH   = 2'd2,
    REG_WINDOW_SIZE = 2'd3
  } cfg_reg_t;

endpackage

[rtl/mps_if.sv]
// ----------------------------------------------------------------------------
// mps_if: channel interfaces of the max pooling stream
// Sample input, pooled result output and configuration write channels, each
// with valid, ready and payload, and a source and a sink modport.
// ----------------------------------------------------------------------------
interface mps_sample_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mps_pool_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pooled_value;
  logic                          tensor_end;

  modport source (output valid, output pooled_value, output tensor_end, input ready);
  modport sink   (input valid, input pooled_value, input tensor_end, output ready);
endinterface

interface mps_cfg_if ();
  import mps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mps_ram.sv]
// ----------------------------------------------------------------------------
// mps_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/max_pooling_stream.sv]
// ----------------------------------------------------------------------------
// max_pooling_stream: streaming non-overlapping 2-D max pooling
// Takes a feature-map tensor one signed sample per beat in raster order
// (channel, row, column) and emits the maximum of every whole square window.
// ----------------------------------------------------------------------------
//
//   Port      Direction  Beat contents
//   samples   in         sample (signed, SAMPLE_BITS)
//   pooled    out        pooled_value (signed, SAMPLE_BITS), tensor_end
//   cfg       in         index (register number), data (register value)
//
// One sample is taken every cycle unless input stalls; each beat needs one
// compare and, at the last column of a window row, one read-modify-write of
// the row store, which is spread over two pipeline stages. Input stalls only
// when the three-entry result queue plus the result in flight would overflow.
// Reset is synchronous; it clears the position counters and the queue. The
// row store is not cleared: each entry is written in the first row of a window
// before any later row reads it. The configuration channel is always ready.
//
module max_pooling_stream #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_POOL    = 8
) (
  input  logic      clk,
  input  logic      rst,
  mps_sample_if.sink  samples,
  mps_pool_if.source  pooled,
  mps_cfg_if.sink     cfg
);
  import mps_pkg::*;

  // Column addressing and the width register follow MAX_WIDTH, the window
  // register and its phases follow MAX_POOL.
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int XB  = WB + 1;
  localparam int RB  = DIM_BITS + 1;
  localparam int PB  = $clog2(MAX_POOL + 1);
  localparam int PHB = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int WIDTH_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // The result queue holds three beats, addressed by two-bit pointers.
  localparam logic [1:0] FIFO_LAST = 2'd2;

  // Clamp a written value into the range one to hi.
  function automatic logic [CFG_DATA_BITS-1:0] clamp_value(
    input logic [CFG_DATA_BITS-1:0] value,
    input logic [CFG_DATA_BITS-1:0] hi
  );
    logic [CFG_DATA_BITS-1:0] res;
    if (value == '0) begin
      res = CFG_DATA_BITS'(1);
    end else if (value > hi) begin
      res = hi;
    end else begin
      res = value;
    end
    return res;
  endfunction

  // Configuration registers.
  logic [WB-1:0]       map_width;
  logic [DIM_BITS-1:0] map_height;
  logic [DIM_BITS-1:0] map_depth;
  logic [PB-1:0]       window_size;

  // Position of the next sample, and the first column and row of its window.
  logic [AW-1:0]         column_count;
  logic [AW-1:0]         column_start;
  logic [AW-1:0]         pool_column;
  logic [COUNT_BITS-1:0] row_count;
  logic [COUNT_BITS-1:0] row_start;
  logic [COUNT_BITS-1:0] channel_count;
  logic [PHB-1:0]        col_phase;
  logic [PHB-1:0]        row_phase;
  logic signed [SAMPLE_BITS-1:0] running_row_max;

  // Second stage: the store read has been issued, the write-back follows.
  logic                          s1_valid;
  logic [AW-1:0]                 s1_index;
  logic signed [SAMPLE_BITS-1:0] s1_max;
  logic                          s1_read_old;
  logic                          s1_emit;
  logic                          s1_last;
  logic                          s1_fwd;
  logic signed [SAMPLE_BITS-1:0] s1_fwd_data;

  // Result queue.
  logic signed [SAMPLE_BITS-1:0] fifo_value [3];
  logic                          fifo_last  [3];
  logic [1:0]                    fifo_wr_ptr;
  logic [1:0]                    fifo_rd_ptr;
  logic [1:0]                    fifo_count;

  logic                          accept;
  logic                          cfg_write;
  logic                          col_whole;
  logic                          row_whole;
  logic                          col_last_phase;
  logic                          row_last_phase;
  logic                          launch;
  logic                          last_col;
  logic                          last_row;
  logic                          last_channel;
  logic                          col_end;
  logic                          row_end;
  logic                          chan_end;
  logic                          col_phase_wrap;
  logic                          row_phase_wrap;
  logic                          fwd_hit;
  logic signed [SAMPLE_BITS-1:0] row_max_start;
  logic signed [SAMPLE_BITS-1:0] row_max_new;
  logic signed [SAMPLE_BITS-1:0] ram_rd_data;
  logic signed [SAMPLE_BITS-1:0] s1_old;
  logic signed [SAMPLE_BITS-1:0] s1_final;
  logic                          push;
  logic                          pop;
  logic [2:0]                    occupancy;
  logic [CFG_DATA_BITS-1:0]      cfg_width_val;
  logic [CFG_DATA_BITS-1:0]      cfg_dim_val;
  logic [CFG_DATA_BITS-1:0]      cfg_window_val;

  // --------------------------------------------------------------------------
  // Handshakes. Input is held back only when every queue slot is spoken for,
  // counting a result that is still in the second stage.
  // --------------------------------------------------------------------------
  assign occupancy     = {1'b0, fifo_count} + {2'b00, s1_valid && s1_emit};
  assign samples.ready = (occupancy <= 3'd2);
  assign accept        = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;
  assign cfg_write     = cfg.valid && cfg.ready;

  assign pooled.valid        = (fifo_count != 2'd0);
  assign pooled.pooled_value = fifo_value[fifo_rd_ptr];
  assign pooled.tensor_end   = fifo_last[fifo_rd_ptr];
  assign pop                 = pooled.valid && pooled.ready;
  assign push                = s1_valid && s1_emit;

  // Clamped register values.
  assign cfg_width_val  = clamp_value(cfg.data, CFG_DATA_BITS'(MAX_WIDTH));
  assign cfg_dim_val    = clamp_value(cfg.data, CFG_DATA_BITS'(DIM_LIMIT));
  assign cfg_window_val = clamp_value(cfg.data, CFG_DATA_BITS'(MAX_POOL));

  // --------------------------------------------------------------------------
  // First stage. A sample counts only while its window lies wholly inside the
  // map: the window's first column or row plus the window side must not pass
  // the map edge. The window is the last whole one in its direction when the
  // next window would pass the edge.
  // --------------------------------------------------------------------------
  assign col_whole      = (XB'(column_start) + XB'(window_size)) <= XB'(map_width);
  assign row_whole      = (RB'(row_start) + RB'(window_size)) <= RB'(map_height);
  assign col_last_phase = (PB'(col_phase) == (window_size - PB'(1)));
  assign row_last_phase = (PB'(row_phase) == (window_size - PB'(1)));
  assign col_phase_wrap = ((PB'(col_phase) + PB'(1)) >= window_size);
  assign row_phase_wrap = ((PB'(row_phase) + PB'(1)) >= window_size);

  assign last_col     = (XB'(column_count) + XB'(window_size) + XB'(1)) > XB'(map_width);
  assign last_row     = (RB'(row_count) + RB'(window_size) + RB'(1)) > RB'(map_height);
  assign last_channel = (DIM_BITS'(channel_count) == (map_depth - DIM_BITS'(1)));

  assign col_end  = (XB'(column_count) + XB'(1)) >= XB'(map_width);
  assign row_end  = (RB'(row_count) + RB'(1)) >= RB'(map_height);
  assign chan_end = (DIM_BITS'(channel_count) + DIM_BITS'(1)) >= map_depth;

  // The running maximum of a window row starts afresh at its first column.
  assign row_max_start = (col_phase == '0) ? MOST_NEG : running_row_max;
  assign row_max_new   = (samples.sample > row_max_start) ? samples.sample : row_max_start;

  // At the last column of a window row the row maximum meets the store.
  assign launch  = accept && col_whole && row_whole && col_last_phase;

  // If the entry being read is written back by the second stage in the same
  // cycle, the store still holds the old value, so the new one is forwarded.
  assign fwd_hit = s1_valid && (s1_index == pool_column);

  // --------------------------------------------------------------------------
  // Second stage: merge with the stored partial maximum of earlier window
  // rows and write it back. The first window row just writes.
  // --------------------------------------------------------------------------
  assign s1_old   = s1_fwd ? s1_fwd_data : ram_rd_data;
  assign s1_final = (s1_read_old && (s1_old > s1_max)) ? s1_old : s1_max;

  mps_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_index),
    .wr_data (s1_final),
    .rd_en   (launch),
    .rd_addr (pool_column),
    .rd_data (ram_rd_data)
  );

  // --------------------------------------------------------------------------
  // Control state: registers, position counters, stage valid and queue.
  // A register write also returns the position to the start of a tensor.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width       <= WB'(WIDTH_RESET);
      map_height      <= DIM_BITS'(HEIGHT_RESET);
      map_depth       <= DIM_BITS'(DEPTH_RESET);
      window_size     <= PB'(WINDOW_RESET);
      column_count    <= '0;
      column_start    <= '0;
      pool_column     <= '0;
      row_count       <= '0;
      row_start       <= '0;
      channel_count   <= '0;
      col_phase       <= '0;
      row_phase       <= '0;
      running_row_max <= MOST_NEG;
      s1_valid        <= 1'b0;
      fifo_wr_ptr     <= '0;
      fifo_rd_ptr     <= '0;
      fifo_count      <= '0;
    end else begin
      s1_valid <= launch;

      if (cfg_write) begin
        case (cfg_reg_t'(cfg.index))
          REG_MAP_WIDTH:   map_width   <= cfg_width_val[WB-1:0];
          REG_MAP_HEIGHT:  map_height  <= cfg_dim_val[DIM_BITS-1:0];
          REG_MAP_DEPTH:   map_depth   <= cfg_dim_val[DIM_BITS-1:0];
          REG_WINDOW_SIZE: window_size <= cfg_window_val[PB-1:0];
          default: ;
        endcase
        column_count    <= '0;
        column_start    <= '0;
        pool_column     <= '0;
        row_count       <= '0;
        row_start       <= '0;
        channel_count   <= '0;
        col_phase       <= '0;
        row_phase       <= '0;
        running_row_max <= MOST_NEG;
      end else if (accept) begin
        if (col_whole && row_whole) begin
          running_row_max <= row_max_new;
        end
        if (col_end) begin
          column_count <= '0;
          column_start <= '0;
          pool_column  <= '0;
          col_phase    <= '0;
          if (row_end) begin
            row_count <= '0;
            row_start <= '0;
            row_phase <= '0;
            channel_count <= chan_end ? '0 : channel_count + COUNT_BITS'(1);
          end else begin
            row_count <= row_count + COUNT_BITS'(1);
            if (row_phase_wrap) begin
              row_phase <= '0;
              row_start <= row_count + COUNT_BITS'(1);
            end else begin
              row_phase <= row_phase + PHB'(1);
            end
          end
        end else begin
          column_count <= column_count + AW'(1);
          if (col_phase_wrap) begin
            col_phase    <= '0;
            column_start <= column_count + AW'(1);
            pool_column  <= pool_column + AW'(1);
          end else begin
            col_phase <= col_phase + PHB'(1);
          end
        end
      end

      if (push) begin
        fifo_wr_ptr <= (fifo_wr_ptr == FIFO_LAST) ? 2'd0 : fifo_wr_ptr + 2'd1;
      end
      if (pop) begin
        fifo_rd_ptr <= (fifo_rd_ptr == FIFO_LAST) ? 2'd0 : fifo_rd_ptr + 2'd1;
      end
      fifo_count <= fifo_count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload registers of the second stage and the queue need no reset.
  always_ff @(posedge clk) begin
    if (launch) begin
      s1_index    <= pool_column;
      s1_max      <= row_max_new;
      s1_read_old <= (row_phase != '0);
      s1_emit     <= row_last_phase;
      s1_last     <= last_channel && last_row && last_col;
      s1_fwd      <= fwd_hit;
      s1_fwd_data <= s1_final;
    end
    if (push) begin
      fifo_value[fifo_wr_ptr] <= s1_final;
      fifo_last[fifo_wr_ptr]  <= s1_last;
    end
  end

endmodule

[rtl/mps_checker.sv]
// ----------------------------------------------------------------------------
// mps_checker: port-level checks for the max pooling stream
// Watches the handshakes of the pooling block and is bound to its top level.
// ----------------------------------------------------------------------------
module mps_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_value_msb,
  input logic out_value_lsb,
  input logic out_last
);

  // Reset leaves an empty result queue and an open input.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("pooling block not empty and ready after reset");

  // Input is only held back while results wait to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // A stalled result beat keeps its end flag and the top and bottom value bits.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_value_msb) && $stable(out_value_lsb) && $stable(out_last)))
    else $error("result beat changed while stalled");

  // A result beat leaves only when taken.
  a_out_leave: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result beat withdrawn without handshake");

endmodule

bind max_pooling_stream mps_checker u_mps_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .out_valid     (pooled.valid),
  .out_ready     (pooled.ready),
  .out_value_msb (pooled.pooled_value[SAMPLE_BITS-1]),
  .out_value_lsb (pooled.pooled_value[0]),
  .out_last      (pooled.tensor_end)
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the max pooling stream
// Streams feature-map tensors into the block under several map and window
// settings, with random idling on both channels. A behavioural predictor
// works out the pooled beats, and a checker compares every returned beat.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mps_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_POOL     = 8;
  // The block has two pipeline stages and a three-entry result queue, so this
  // many quiet cycles after the last pooled beat leave it fully idle.
  localparam int DRAIN_CYCLES = 16;
  // Sample beats given to the random maps; the other tests add a few hundred.
  localparam int RANDOM_ITEMS = 850;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int REPORT_LIMIT = 100;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t value;
    logic    last;
  } pool_beat_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic clk;
  logic rst;

  mps_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples ();
  mps_pool_if   #(.SAMPLE_BITS(SAMPLE_BITS)) pooled ();
  mps_cfg_if                                 cfg ();

  max_pooling_stream #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_POOL   (MAX_POOL)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples),
    .pooled (pooled),
    .cfg    (cfg)
  );

  // Predictor state: the register settings, the raster position of the next
  // sample, the phase inside the current window, the running maximum of the
  // current window row and the per-window-column maxima of earlier rows.
  int unsigned map_w, map_h, map_d, win;
  int unsigned col, row, chan, col_phase, row_phase;
  sample_t     row_max;
  sample_t     column_max [MAX_WIDTH];

  // Pooled beats still owed by the block, oldest first.
  pool_beat_t  pending_pools [$];

  int          errors = 0;
  bit          idling = 1'b1;
  int unsigned stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Every write, and reset, puts the scan back at the start of a tensor.
  function automatic void restart_scan();
    col       = 0;
    row       = 0;
    chan      = 0;
    col_phase = 0;
    row_phase = 0;
    row_max   = SAMPLE_MIN;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned value, int unsigned hi);
    if (value < 1) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  // Register values outside the legal range are pinned to the nearer bound.
  function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
    case (idx)
      REG_MAP_WIDTH:   map_w = clamp_dim(value, MAX_WIDTH);
      REG_MAP_HEIGHT:  map_h = clamp_dim(value, DIM_LIMIT);
      REG_MAP_DEPTH:   map_d = clamp_dim(value, DIM_LIMIT);
      REG_WINDOW_SIZE: win   = clamp_dim(value, MAX_POOL);
      default: ;
    endcase
    restart_scan();
  endfunction

  // Folds one accepted sample into the window state and queues a pooled beat
  // when it completes a window. Samples in the ragged right columns and
  // bottom rows are simply skipped over by the block.
  function automatic void pool_sample(sample_t s);
    int unsigned used_cols;
    int unsigned used_rows;
    int unsigned slot;
    sample_t     start;
    sample_t     peak;
    bit          in_window;
    used_cols = (map_w / win) * win;
    used_rows = (map_h / win) * win;
    in_window = (col < used_cols) && (row < used_rows);
    if (in_window) begin
      // A new window row starts from the most negative sample value.
      start   = (col_phase == 0) ? SAMPLE_MIN : row_max;
      peak    = (s > start) ? s : start;
      row_max = peak;
      if (col_phase == win - 1) begin
        // The first window row overwrites the column entry; later rows merge.
        slot = col / win;
        if (row_phase != 0 && column_max[slot] > peak) begin
          peak = column_max[slot];
        end
        column_max[slot] = peak;
        if (row_phase == win - 1) begin
          pending_pools.push_back('{value: peak,
                                    last: (chan == map_d - 1 && row == used_rows - 1 &&
                                           col == used_cols - 1)});
        end
      end
    end
    // Raster advance: column, then row, then channel, wrapping at tensor end.
    col_phase = (col_phase + 1 >= win) ? 0 : col_phase + 1;
    col++;
    if (col >= map_w) begin
      col       = 0;
      col_phase = 0;
      row_phase = (row_phase + 1 >= win) ? 0 : row_phase + 1;
      row++;
      if (row >= map_h) begin
        row       = 0;
        row_phase = 0;
        chan      = (chan + 1 >= map_d) ? 0 : chan + 1;
      end
    end
  endfunction

  // Result checker: every pooled beat taken at a rising edge is matched with
  // the oldest expectation. Reporting is capped so a badly broken block
  // cannot flood the log; the error count still covers every mismatch.
  always @(posedge clk) begin : check_pooled
    pool_beat_t want;
    if (!rst && pooled.valid === 1'b1 && pooled.ready === 1'b1) begin
      if (pending_pools.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("%0t: unexpected pooled beat, expected none, actual value %0d tensor_end %0b",
                   $time, pooled.pooled_value, pooled.tensor_end);
        end
      end else begin
        want = pending_pools.pop_front();
        if (pooled.pooled_value !== want.value) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: pooled_value expected %0d, actual %0d", $time,
                     want.value, pooled.pooled_value);
          end
        end
        if (pooled.tensor_end !== want.last) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: tensor_end expected %0b, actual %0b", $time,
                     want.last, pooled.tensor_end);
          end
        end
      end
    end
  end

  // Result sink: while idling is enabled, ready drops low in random bursts;
  // otherwise it stays high once any burst under way has run out.
  initial begin
    pooled.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        pooled.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        pooled.ready <= 1'b0;
      end else begin
        pooled.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: errors");
    $finish;
  end

  // All driving tasks are entered and left on a falling edge. The sample
  // valid is lowered here only for an idle gap before a beat, so back-to-back
  // beats keep it high; callers lower it through hold_until_drained.
  task automatic send_sample(input sample_t s);
    if (idling && $urandom_range(0, 3) == 0) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    samples.valid  <= 1'b1;
    samples.sample <= s;
    @(posedge clk);
    while (samples.ready !== 1'b1) @(posedge clk);
    pool_sample(s);
    @(negedge clk);
  endtask

  // Stops the sample stream and waits until every owed beat has come back,
  // then lets the pipeline empty. Also used as the pause under back-pressure.
  task automatic hold_until_drained();
    samples.valid <= 1'b0;
    @(negedge clk);
    while (pending_pools.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (cfg.ready !== 1'b1) @(posedge clk);
    apply_reg(idx, value);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_map(input logic [CFG_DATA_BITS-1:0] width, height, depth, window);
    write_reg(REG_MAP_WIDTH, width);
    write_reg(REG_MAP_HEIGHT, height);
    write_reg(REG_MAP_DEPTH, depth);
    write_reg(REG_WINDOW_SIZE, window);
  endtask

  // Random samples lean on the two extremes and on values near zero so that
  // ties and sign changes turn up often inside a window.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return sample_t'($urandom_range(0, 15)) - sample_t'(8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Sends n random samples; when hold_at is non-zero the stream pauses after
  // that beat until the block has caught up.
  task automatic stream_samples(input int n, input int hold_at);
    for (int i = 1; i <= n; i++) begin
      send_sample(random_sample());
      if (i == hold_at) hold_until_drained();
    end
    hold_until_drained();
  endtask

  // Small random maps keep the run short; windows above four are rarer.
  task automatic random_map();
    int unsigned window;
    window = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_POOL) : $urandom_range(1, 4);
    set_map(CFG_DATA_BITS'($urandom_range(1, 12)), CFG_DATA_BITS'($urandom_range(1, 10)),
            CFG_DATA_BITS'($urandom_range(1, 3)), CFG_DATA_BITS'(window));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings are a 1024-wide map with 2x2 windows: a short stretch of
  // the first row yields nothing. Narrowing only the width then leaves the
  // reset height, depth and window, and two rows give a row of pooled beats.
  task automatic test_reset_defaults();
    stream_samples(8, 0);
    write_reg(REG_MAP_WIDTH, 16'd8);
    stream_samples(16, 0);
  endtask

  task automatic test_directed_values();
    sample_t corner [20] = '{
      // First tensor: one window of only the most negative value, so the
      // start value must not leak through, then a window with the maximum.
      SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, -16'sd1,
      SAMPLE_MIN, SAMPLE_MIN, 16'sd0,     16'sd1,
      // Second tensor straight after the first: the scan must have wrapped.
      -16'sd1,    16'sh0100,  -16'sd32767, 16'sd0,
      16'sh7ffe,  -16'sd2,    16'sd5,      SAMPLE_MAX,
      // Map smaller than the window: consumed, nothing comes out.
      16'sd1,     16'sd2,     16'sd3,      16'sd4
    };
    set_map(16'd4, 16'd2, 16'd1, 16'd2);
    for (int i = 0; i < 16; i++) begin
      send_sample(corner[i]);
      // Pause once mid-tensor, straight after the first window completes.
      if (i == 5) hold_until_drained();
    end
    hold_until_drained();

    set_map(16'd2, 16'd2, 16'd1, 16'd3);
    for (int i = 16; i < 20; i++) send_sample(corner[i]);
    hold_until_drained();

    // A register write part-way through a tensor restarts the scan: after the
    // window is cut to one, the next four beats are a whole row of results.
    set_map(16'd4, 16'd2, 16'd1, 16'd2);
    for (int i = 0; i < 3; i++) send_sample(random_sample());
    hold_until_drained();
    write_reg(REG_WINDOW_SIZE, 16'd1);
    for (int i = 0; i < 4; i++) send_sample(random_sample());
    hold_until_drained();
  endtask

  // Register bounds, written both at the bound and beyond it.
  task automatic test_register_extremes();
    // Widest map, single row and channel, window of one: the opening columns
    // of the row each give a beat.
    set_map(16'hffff, 16'd0, 16'd0, 16'd0);
    stream_samples(8, 0);
    // Tallest map, one column wide.
    set_map(16'd0, 16'd2000, 16'd1, 16'd1);
    stream_samples(4, 0);
    // Deepest tensor of single samples.
    set_map(16'd1, 16'd1, 16'hffff, 16'd1);
    stream_samples(4, 0);
    // Largest window, pinned from an oversized value, over one whole map.
    set_map(16'd8, 16'd8, 16'd1, 16'd15);
    stream_samples(64, 0);
    // Largest window with a ragged right column and bottom row.
    set_map(16'd9, 16'd9, 16'd1, CFG_DATA_BITS'(MAX_POOL));
    stream_samples(81, 0);
  endtask

  // Random maps with random content; mostly whole tensors, sometimes two in
  // a row, sometimes cut short, and now and then a single register rewrite.
  task automatic test_random_maps();
    int sent;
    int n;
    int hold_at;
    int maps;
    sent = 0;
    maps = 0;
    while (sent < RANDOM_ITEMS) begin
      if (maps != 0 && $urandom_range(0, 5) == 0) begin
        write_reg(REG_WINDOW_SIZE, CFG_DATA_BITS'($urandom_range(1, 4)));
      end else begin
        random_map();
      end
      // Some maps run without any idling at all.
      idling = ($urandom_range(0, 3) != 0);
      n = int'(map_w * map_h * map_d) * int'($urandom_range(1, 2));
      if ($urandom_range(0, 4) == 0) n = int'($urandom_range(1, n));
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      hold_at = (maps == 0 || $urandom_range(0, 7) == 0) ? int'($urandom_range(1, n)) : 0;
      stream_samples(n, hold_at);
      sent += n;
      maps++;
    end
    idling = 1'b1;
  endtask

  // The closing stretch runs at full rate on both channels.
  task automatic test_full_rate();
    idling = 1'b0;
    random_map();
    stream_samples(int'(map_w * map_h * map_d), 0);
  endtask

  initial begin
    samples.valid  <= 1'b0;
    samples.sample <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= REG_MAP_WIDTH;
    cfg.data       <= '0;
    rst            <= 1'b1;
    map_w = MAX_WIDTH;
    map_h = HEIGHT_RESET;
    map_d = DEPTH_RESET;
    win   = WINDOW_RESET;
    restart_scan();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_directed_values();
    test_register_extremes();
    test_random_maps();
    test_full_rate();

    hold_until_drained();
    if (errors == 0 && pending_pools.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[max_pooling_stream.f]
rtl/mps_pkg.sv
rtl/mps_if.sv
rtl/mps_ram.sv
rtl/max_pooling_stream.sv
rtl/mps_checker.sv
verif/tb.sv
